[hdl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

[hdl/bdsm_pkg.sv]
`timescale 1ns / 1ps

package bdsm_pkg;

  // Position of every level in the combined sample vector.
  localparam int LEVEL_COUNT = 21;
  localparam int FACE_COUNT  = 14;
  localparam int BIT_SELECT  = 11;
  localparam int BIT_START   = 12;
  localparam int BIT_HOME    = 13;
  localparam int BIT_UP      = 14;
  localparam int BIT_DOWN    = 15;
  localparam int BIT_RIGHT   = 16;
  localparam int BIT_LEFT    = 17;
  localparam int BIT_LOCK    = 18;
  localparam int BIT_LS      = 19;
  localparam int BIT_RS      = 20;

  // Register map, indexed by address bit 2.
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_LOCK     = 1'b1;

  localparam logic [31:0] DEBOUNCE_RESET = 32'd5000;
  localparam logic        LOCK_RESET     = 1'b1;

  localparam logic [7:0] AXIS_LOW  = 8'h00;
  localparam logic [7:0] AXIS_MID  = 8'h80;
  localparam logic [7:0] AXIS_HIGH = 8'hFF;

  localparam logic [3:0] DPAD_NEUTRAL = 4'd0;
  localparam logic [3:0] DPAD_N       = 4'd1;
  localparam logic [3:0] DPAD_NE      = 4'd2;
  localparam logic [3:0] DPAD_E       = 4'd3;
  localparam logic [3:0] DPAD_SE      = 4'd4;
  localparam logic [3:0] DPAD_S       = 4'd5;
  localparam logic [3:0] DPAD_SW      = 4'd6;
  localparam logic [3:0] DPAD_W       = 4'd7;
  localparam logic [3:0] DPAD_NW      = 4'd8;

  typedef struct packed {
    logic [FACE_COUNT-1:0] buttons;
    logic [3:0]            dpad;
    logic [7:0]            left_x;
    logic [7:0]            left_y;
    logic [7:0]            right_x;
    logic [7:0]            right_y;
    logic                  lock;
  } result_t;

  function automatic logic [7:0] axis_value(input logic neg, input logic pos);
    logic [7:0] val;
    if (neg) val = AXIS_LOW;
    else if (pos) val = AXIS_HIGH;
    else val = AXIS_MID;
    return val;
  endfunction

  function automatic logic [3:0] dpad_of(input logic h_neg, input logic h_pos,
                                         input logic v_neg, input logic v_pos);
    logic [3:0] code;
    if (v_neg) begin
      code = h_neg ? DPAD_NW : (h_pos ? DPAD_NE : DPAD_N);
    end else if (v_pos) begin
      code = h_neg ? DPAD_SW : (h_pos ? DPAD_SE : DPAD_S);
    end else begin
      code = h_neg ? DPAD_W : (h_pos ? DPAD_E : DPAD_NEUTRAL);
    end
    return code;
  endfunction

endpackage

[hdl/button_debounce_stick_mapper_core.sv]
`timescale 1ns / 1ps

// Button debounce and stick mapper.
// Input channel: one sample of face buttons, direction pins, mode pins and
// the free-running tick per transfer (in_valid_i / in_stall_o). Output
// channel: one result per sample (out_valid_o / out_stall_i) with the
// debounced buttons, dpad code, four stick axes and the lock flag.
// A sample shows at the output register in the cycle after it is taken.
// Throughput is one sample per cycle while the receiver does not stall; all
// button debouncers run side by side, each doing one tick subtract and
// threshold compare, and the mapping stage follows in the same cycle.
// When the receiver stalls, the result holds and input is taken only in a
// cycle where the held result leaves, so nothing is lost or repeated.
// Reset clears every debounced level and change tick to zero, empties the
// output register, and loads debounce_ticks = 5000 and lock_enable = 1.
// Registers over APB: debounce_ticks at 0x0, lock_enable at 0x4; write them
// only while no sample is in flight.
module button_debounce_stick_mapper_core #(
  parameter int NUM_BUTTONS = 21,
  parameter int TICK_BITS   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [13:0]          face_buttons_i,
  input  logic [3:0]           direction_pins_i,
  input  logic [2:0]           mode_pins_i,
  input  logic [TICK_BITS-1:0] now_tick_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [13:0]          buttons_out_o,
  output logic [3:0]           dpad_code_o,
  output logic [7:0]           left_x_o,
  output logic [7:0]           left_y_o,
  output logic [7:0]           right_x_o,
  output logic [7:0]           right_y_o,
  output logic                 lock_active_o
);
  import bdsm_pkg::*;

  logic [31:0] debounce_q;
  logic        lock_enable_q;
  logic        cfg_write;

  logic [LEVEL_COUNT-1:0] raw;
  logic [LEVEL_COUNT-1:0] levels;
  logic                   take;
  result_t                result;
  result_t                out_q;
  logic                   out_valid_q;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DEBOUNCE_RESET;
      lock_enable_q <= LOCK_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_DEBOUNCE: debounce_q    <= pwdata;
        REG_LOCK:     lock_enable_q <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE: prdata = debounce_q;
      REG_LOCK:     prdata = {31'd0, lock_enable_q};
      default:      prdata = '0;
    endcase
  end

  // A new sample is taken whenever the output register is empty or its
  // result leaves in this cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign take       = in_valid_i & ~in_stall_o;

  assign raw = {mode_pins_i, direction_pins_i, face_buttons_i};

  for (genvar i = 0; i < LEVEL_COUNT; i++) begin : g_lane
    if (i < NUM_BUTTONS) begin : g_debounce
      bdsm_lane #(
        .TICK_BITS(TICK_BITS)
      ) u_lane (
        .clk_i           (clk_i),
        .rst_ni          (rst_ni),
        .take_i          (take),
        .raw_i           (raw[i]),
        .now_i           (now_tick_i),
        .debounce_ticks_i(debounce_q),
        .level_o         (levels[i])
      );
    end else begin : g_pass
      // Buttons beyond the configured count are not debounced.
      assign levels[i] = raw[i];
    end
  end

  bdsm_map u_map (
    .levels_i     (levels),
    .lock_enable_i(lock_enable_q),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign buttons_out_o = out_q.buttons;
  assign dpad_code_o   = out_q.dpad;
  assign left_x_o      = out_q.left_x;
  assign left_y_o      = out_q.left_y;
  assign right_x_o     = out_q.right_x;
  assign right_y_o     = out_q.right_y;
  assign lock_active_o = out_q.lock;

endmodule

[hdl/bdsm_lane.sv]
`timescale 1ns / 1ps

module bdsm_lane #(
  parameter int TICK_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic                 raw_i,
  input  logic [TICK_BITS-1:0] now_i,
  input  logic [31:0]          debounce_ticks_i,
  output logic                 level_o
);

  // The compare runs at the wider of the tick and the threshold widths.
  localparam int CMP_BITS = (TICK_BITS > 32) ? TICK_BITS : 32;

  logic                 level_q, level_d;
  logic [TICK_BITS-1:0] tick_q, tick_d;
  logic [TICK_BITS-1:0] elapsed;
  logic                 accept_change;

  assign elapsed       = now_i - tick_q;
  assign accept_change = (raw_i != level_q) &&
                         (CMP_BITS'(elapsed) >= CMP_BITS'(debounce_ticks_i));

  always_comb begin
    level_d = level_q;
    tick_d  = tick_q;
    if (accept_change) begin
      level_d = raw_i;
      tick_d  = now_i;
    end
  end

  assign level_o = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      tick_q  <= '0;
    end else if (take_i) begin
      level_q <= level_d;
      tick_q  <= tick_d;
    end
  end

endmodule

[hdl/bdsm_map.sv]
`timescale 1ns / 1ps

module bdsm_map (
  input  logic [bdsm_pkg::LEVEL_COUNT-1:0] levels_i,
  input  logic                             lock_enable_i,
  output bdsm_pkg::result_t                result_o
);
  import bdsm_pkg::*;

  logic lock;
  logic h_neg, h_pos, v_neg, v_pos;
  logic [FACE_COUNT-1:0] lock_mask;

  assign lock = lock_enable_i & levels_i[BIT_LOCK];

  // Opposing directions cancel on their axis.
  assign v_neg = levels_i[BIT_UP] & ~levels_i[BIT_DOWN];
  assign v_pos = levels_i[BIT_DOWN] & ~levels_i[BIT_UP];
  assign h_neg = levels_i[BIT_LEFT] & ~levels_i[BIT_RIGHT];
  assign h_pos = levels_i[BIT_RIGHT] & ~levels_i[BIT_LEFT];

  always_comb begin
    lock_mask             = '1;
    lock_mask[BIT_SELECT] = 1'b0;
    lock_mask[BIT_START]  = 1'b0;
    lock_mask[BIT_HOME]   = 1'b0;

    result_o.buttons = lock ? (levels_i[FACE_COUNT-1:0] & lock_mask)
                            : levels_i[FACE_COUNT-1:0];
    result_o.lock    = lock;
    result_o.dpad    = DPAD_NEUTRAL;
    result_o.left_x  = AXIS_MID;
    result_o.left_y  = AXIS_MID;
    result_o.right_x = AXIS_MID;
    result_o.right_y = AXIS_MID;

    // Left-stick mode takes priority over right-stick mode.
    if (levels_i[BIT_LS]) begin
      result_o.left_x = axis_value(h_neg, h_pos);
      result_o.left_y = axis_value(v_neg, v_pos);
    end else if (levels_i[BIT_RS]) begin
      result_o.right_x = axis_value(h_neg, h_pos);
      result_o.right_y = axis_value(v_neg, v_pos);
    end else begin
      result_o.dpad = dpad_of(h_neg, h_pos, v_neg, v_pos);
    end
  end

endmodule

[hdl/bdsm_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [13:0] buttons_out_o,
  input logic [3:0]  dpad_code_o,
  input logic [7:0]  left_x_o,
  input logic [7:0]  right_x_o,
  input logic        lock_active_o
);

  // A held result is never dropped while the receiver stalls.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // The input side only stalls when a result is stuck at the output.
  `ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // Every taken sample produces a result in the next cycle.
  `ASSERT_NEXT(a_take_result, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)

  // While locked, select, start and home read as zero.
  `ASSERT_IMPLY(a_lock_mask, clk_i, rst_ni, out_valid_o && lock_active_o,
                buttons_out_o[13:11] == 3'b000)

  // A dpad code only appears with the x axes of both sticks centered.
  `ASSERT_IMPLY(a_dpad_sticks, clk_i, rst_ni, out_valid_o && (dpad_code_o != 4'd0),
                (left_x_o == 8'h80) && (right_x_o == 8'h80))

endmodule

bind button_debounce_stick_mapper_core bdsm_checker u_bdsm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .buttons_out_o(buttons_out_o),
  .dpad_code_o  (dpad_code_o),
  .left_x_o     (left_x_o),
  .right_x_o    (right_x_o),
  .lock_active_o(lock_active_o)
);
